// File: src/gcdpf_pkg.sv
// Package for the prime-factor-merge GCD unit.
// Holds sizing constants and the command and status structs between controller and datapath.
// No dependencies.
package gcdpf_pkg;

  localparam int OperandBits = 16;
  localparam int MaxFactors  = 16;
  localparam int CountBits   = $clog2(MaxFactors + 1);
  localparam int IdxBits     = $clog2(MaxFactors);
  localparam int DivCntBits  = $clog2(OperandBits + 1);

  localparam logic [OperandBits-1:0] FirstCand   = OperandBits'(2);
  localparam logic [OperandBits:0]   FirstSquare = (OperandBits + 1)'(4);
  localparam logic [OperandBits-1:0] ProductInit = OperandBits'(1);

  typedef struct packed {
    logic load_in;
    logic init_fac;
    logic sel;
    logic push_rest;
    logic div_start;
    logic div_hit;
    logic next_cand;
    logic merge_init;
    logic merge_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic rest_le1;
    logic sq_gt_rest;
    logic div_done;
    logic rem_zero;
    logic merge_end;
  } status_t;

endpackage

// File: src/gcdpf_dpath.sv
// Datapath of the prime-factor-merge GCD unit: operand and trial registers,
// shared restoring divider, two factor stores and the merge product.
// Depends on gcdpf_pkg.
module gcdpf_dpath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  gcdpf_pkg::cmd_t                     cmd_i,
  input  logic [gcdpf_pkg::OperandBits-1:0]   first_value_i,
  input  logic [gcdpf_pkg::OperandBits-1:0]   second_value_i,
  output gcdpf_pkg::status_t                  status_o,
  output logic [gcdpf_pkg::OperandBits-1:0]   divisor_o
);

  localparam int N = gcdpf_pkg::OperandBits;

  logic [N-1:0] a_q, b_q;
  logic [N-1:0] rest_q, cand_q;
  logic [N:0]   sq_q;
  logic [gcdpf_pkg::CountBits-1:0] cnt0_q, cnt1_q, ta_q, tb_q, cur_cnt;
  logic [gcdpf_pkg::IdxBits-1:0]   ta_idx, tb_idx;
  logic [N-1:0] mem0 [gcdpf_pkg::MaxFactors];
  logic [N-1:0] mem1 [gcdpf_pkg::MaxFactors];
  logic [N-1:0] rd0_q, rd1_q;
  logic [N-1:0] rem_q, quo_q;
  logic [gcdpf_pkg::DivCntBits-1:0] dcnt_q;
  logic [N:0]   shifted, diff;
  logic         ge;
  logic [N-1:0] product_q, divisor_q, push_val;
  logic [2*N-1:0] mul;
  logic         push, push_ok;

  assign push     = cmd_i.push_rest | cmd_i.div_hit;
  assign push_val = cmd_i.push_rest ? rest_q : cand_q;
  assign cur_cnt  = cmd_i.sel ? cnt1_q : cnt0_q;
  assign push_ok  = cur_cnt < gcdpf_pkg::CountBits'(gcdpf_pkg::MaxFactors);

  assign ta_idx = gcdpf_pkg::IdxBits'(ta_q - gcdpf_pkg::CountBits'(1));
  assign tb_idx = gcdpf_pkg::IdxBits'(tb_q - gcdpf_pkg::CountBits'(1));

  assign shifted = {rem_q, quo_q[N-1]};
  assign ge      = shifted >= {1'b0, cand_q};
  assign diff    = shifted - {1'b0, cand_q};

  assign mul = {{N{1'b0}}, product_q} * {{N{1'b0}}, rd0_q};

  // Factor counts and divider step count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt0_q <= '0;
      cnt1_q <= '0;
      dcnt_q <= '0;
    end else begin
      if (cmd_i.init_fac) begin
        if (cmd_i.sel) cnt1_q <= '0;
        else cnt0_q <= '0;
      end else if (push && push_ok) begin
        if (cmd_i.sel) cnt1_q <= cnt1_q + gcdpf_pkg::CountBits'(1);
        else cnt0_q <= cnt0_q + gcdpf_pkg::CountBits'(1);
      end
      if (cmd_i.div_start) begin
        dcnt_q <= gcdpf_pkg::DivCntBits'(N);
      end else if (dcnt_q != '0) begin
        dcnt_q <= dcnt_q - gcdpf_pkg::DivCntBits'(1);
      end
    end
  end

  // Factor stores with registered top reads
  always_ff @(posedge clk_i) begin
    if (push && push_ok && !cmd_i.sel) mem0[cnt0_q[gcdpf_pkg::IdxBits-1:0]] <= push_val;
    if (push && push_ok && cmd_i.sel)  mem1[cnt1_q[gcdpf_pkg::IdxBits-1:0]] <= push_val;
    rd0_q <= mem0[ta_idx];
    rd1_q <= mem1[tb_idx];
  end

  // Operands, trial state, divider, merge
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      a_q       <= first_value_i;
      b_q       <= second_value_i;
      product_q <= gcdpf_pkg::ProductInit;
    end
    if (cmd_i.init_fac) begin
      rest_q <= cmd_i.sel ? b_q : a_q;
      cand_q <= gcdpf_pkg::FirstCand;
      sq_q   <= gcdpf_pkg::FirstSquare;
    end else if (cmd_i.div_hit) begin
      rest_q <= quo_q;
    end else if (cmd_i.next_cand) begin
      cand_q <= cand_q + N'(1);
      sq_q   <= sq_q + {cand_q, 1'b1};
    end
    if (cmd_i.div_start) begin
      rem_q <= '0;
      quo_q <= rest_q;
    end else if (dcnt_q != '0) begin
      rem_q <= ge ? diff[N-1:0] : shifted[N-1:0];
      quo_q <= {quo_q[N-2:0], ge};
    end
    if (cmd_i.merge_init) begin
      ta_q <= cnt0_q;
      tb_q <= cnt1_q;
    end else if (cmd_i.merge_step) begin
      if (rd0_q == rd1_q) begin
        product_q <= mul[N-1:0];
        ta_q      <= ta_q - gcdpf_pkg::CountBits'(1);
        tb_q      <= tb_q - gcdpf_pkg::CountBits'(1);
      end else if (rd0_q > rd1_q) begin
        ta_q <= ta_q - gcdpf_pkg::CountBits'(1);
      end else begin
        tb_q <= tb_q - gcdpf_pkg::CountBits'(1);
      end
    end
    if (cmd_i.out_load) divisor_q <= product_q;
  end

  assign status_o.rest_le1   = rest_q <= N'(1);
  assign status_o.sq_gt_rest = sq_q > {1'b0, rest_q};
  assign status_o.div_done   = dcnt_q == '0;
  assign status_o.rem_zero   = rem_q == '0;
  assign status_o.merge_end  = (ta_q == '0) || (tb_q == '0);
  assign divisor_o           = divisor_q;

endmodule

// File: src/gcdpf_ctrl.sv
// Controller of the prime-factor-merge GCD unit: sequences trial division
// of both operands, the merge of the factor stores and the result transfer.
// Depends on gcdpf_pkg.
module gcdpf_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  gcdpf_pkg::status_t status_i,
  output gcdpf_pkg::cmd_t    cmd_o
);

  typedef enum logic [8:0] {
    StIdle      = 9'b000000001,
    StFacInit   = 9'b000000010,
    StFacCheck  = 9'b000000100,
    StFacDiv    = 9'b000001000,
    StFacRediv  = 9'b000010000,
    StMergeInit = 9'b000100000,
    StMergeRd   = 9'b001000000,
    StMergeCmp  = 9'b010000000,
    StFinish    = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic   sel_q, sel_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    sel_d   = sel_q;
    cmd_o   = '0;
    cmd_o.sel = sel_q;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          sel_d   = 1'b0;
          state_d = StFacInit;
        end
      end
      StFacInit: begin
        cmd_o.init_fac = 1'b1;
        state_d = StFacCheck;
      end
      StFacCheck: begin
        if (status_i.rest_le1 || status_i.sq_gt_rest) begin
          cmd_o.push_rest = !status_i.rest_le1;
          if (!sel_q) begin
            sel_d   = 1'b1;
            state_d = StFacInit;
          end else begin
            state_d = StMergeInit;
          end
        end else begin
          cmd_o.div_start = 1'b1;
          state_d = StFacDiv;
        end
      end
      StFacDiv: begin
        if (status_i.div_done) begin
          if (status_i.rem_zero) begin
            cmd_o.div_hit = 1'b1;
            state_d = StFacRediv;
          end else begin
            cmd_o.next_cand = 1'b1;
            state_d = StFacCheck;
          end
        end
      end
      StFacRediv: begin
        cmd_o.div_start = 1'b1;
        state_d = StFacDiv;
      end
      StMergeInit: begin
        cmd_o.merge_init = 1'b1;
        state_d = StMergeRd;
      end
      StMergeRd: begin
        state_d = StMergeCmp;
      end
      StMergeCmp: begin
        if (status_i.merge_end) begin
          state_d = StFinish;
        end else begin
          cmd_o.merge_step = 1'b1;
          state_d = StMergeRd;
        end
      end
      StFinish: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      sel_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sel_q       <= sel_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = state_q == StIdle;
  assign out_valid_o = out_valid_q;

endmodule

// File: src/gcd_by_prime_factor_merge.sv
// GCD by prime-factor merge. Each operand is factored by trial division on the
// shared bit-serial restoring divider; the two factor stores are then merged,
// multiplying each common factor into the product.
// One item at a time; the next is accepted once the result sits in the output register.
// Reset: controller idle, factor counts zero, no result valid; stores are not cleared.
module gcd_by_prime_factor_merge (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [gcdpf_pkg::OperandBits-1:0] first_value_i,
  input  logic [gcdpf_pkg::OperandBits-1:0] second_value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [gcdpf_pkg::OperandBits-1:0] divisor_o
);

  gcdpf_pkg::cmd_t    cmd;
  gcdpf_pkg::status_t status;

  gcdpf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  gcdpf_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .first_value_i  (first_value_i),
    .second_value_i (second_value_i),
    .status_o       (status),
    .divisor_o      (divisor_o)
  );

`ifndef NO_ASSERTIONS
  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input transfer did not start work");

  a_div_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_start |=> !status.div_done)
    else $error("divider not busy after start");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!out_valid_o || out_ready_i))
    else $error("pending result overwritten");

  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_in |-> in_ready_o)
    else $error("operands loaded while busy");
`endif

endmodule
